>>> hw/rtl/tnes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnes_pkg
// Shared types and constants of the timed note event sequencer: request and
// event codes, register indexes, stored event layout, control and status.
// ----------------------------------------------------------------------------
package tnes_pkg;

    localparam int unsigned CNT_W      = 9;
    localparam int unsigned MPT_W      = 24;
    localparam int unsigned REM_W      = 24;
    localparam int unsigned DELTA_W    = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PROD_W     = DELTA_W + MPT_W;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CNT_W-1:0]  EVENT_COUNT_RESET = '0;
    localparam logic [MPT_W-1:0]  MS_PER_TICK_RESET = 24'h010000;
    localparam logic [PROD_W-1:0] ROUND_HALF        = PROD_W'(32768);

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EVENT_COUNT = 1'b0,
        REG_MS_PER_TICK = 1'b1
    } reg_idx_t;

    localparam logic [BYTE_W-1:0] KIND_NOTE_OFF = 8'd0;
    localparam logic [BYTE_W-1:0] KIND_NOTE_ON  = 8'd1;

    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [BYTE_W-1:0]  kind;
        logic [BYTE_W-1:0]  note;
        logic [BYTE_W-1:0]  vel;
    } event_t;

    typedef struct packed {
        logic capture;
        logic mem_write;
        logic stop;
        logic start_play;
        logic count_down;
        logic finish;
        logic rd_first;
        logic rd_cur;
        logic rd_next;
        logic fire;
        logic mul;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic active;
        logic can_start;
        logic rem_le1;
        logic at_end;
        logic next_in_range;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/timed_note_event_sequencer.sv
// ----------------------------------------------------------------------------
// Timed note event sequencer: one request per transfer, one result strobe.
// Done follows DECODE for write, stop, ignored start, non-firing ticks; MUL,
// LOAD for start; FIRE, MUL, LOAD for a firing tick; FIRE for the last event.
// Next accept the cycle after done. Reset: async active low, idle, count 0.
// ----------------------------------------------------------------------------
`default_nettype none
module timed_note_event_sequencer #(
    parameter int MAX_EVENTS = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [tnes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tnes_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       req_type,
    input  wire logic [7:0]                       write_index,
    input  wire logic [15:0]                      wait_ticks,
    input  wire logic [7:0]                       event_kind,
    input  wire logic [7:0]                       note_in,
    input  wire logic [7:0]                       velocity_in,
    output logic                                  done,
    output logic                                  note_valid,
    output logic                                  note_on,
    output logic [7:0]                            note_out,
    output logic [7:0]                            velocity_out,
    output logic                                  playing,
    output logic                                  finished
);
    import tnes_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tnes_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tnes_dp #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .write_index  (write_index),
        .wait_ticks   (wait_ticks),
        .event_kind   (event_kind),
        .note_in      (note_in),
        .velocity_in  (velocity_in),
        .cmd          (cmd),
        .status       (status),
        .note_valid   (note_valid),
        .note_on      (note_on),
        .note_out     (note_out),
        .velocity_out (velocity_out),
        .playing      (playing),
        .finished     (finished)
    );

`ifndef NO_ASSERTIONS
    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_done_release : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result transfer");

    a_finish_stops : assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |-> (!playing && !note_valid))
        else $error("finished with playback still active or a note");

    a_note_playing : assert property (@(posedge clk) disable iff (!rst_n)
        (done && note_valid) |-> playing)
        else $error("note issued while not playing");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/tnes_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnes_dp
// Datapath: configuration registers, event store, position and millisecond
// countdown, delay multiplier with rounding, and result registers.
// ----------------------------------------------------------------------------
module tnes_dp #(
    parameter int MAX_EVENTS = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [tnes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tnes_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [1:0]                       req_type,
    input  wire logic [7:0]                       write_index,
    input  wire logic [15:0]                      wait_ticks,
    input  wire logic [7:0]                       event_kind,
    input  wire logic [7:0]                       note_in,
    input  wire logic [7:0]                       velocity_in,
    input  wire tnes_pkg::dp_cmd_t                cmd,
    output tnes_pkg::dp_status_t                  status,
    output logic                                  note_valid,
    output logic                                  note_on,
    output logic [7:0]                            note_out,
    output logic [7:0]                            velocity_out,
    output logic                                  playing,
    output logic                                  finished
);
    import tnes_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MAX_EVENTS);
    localparam int unsigned CAP    = (MAX_EVENTS < 512) ? MAX_EVENTS : 511;

    event_t               store_mem [MAX_EVENTS];
    event_t               rdata_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [MPT_W-1:0]     mpt_reg;
    req_t                 req_reg;
    logic [7:0]           idx_reg;
    event_t               wr_reg;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 active_reg, active_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    rounded;
    logic                 nv_reg, nv_next;
    logic                 on_reg, on_next;
    logic [BYTE_W-1:0]    note_reg, note_next;
    logic [BYTE_W-1:0]    vel_reg, vel_next;
    logic                 fin_reg, fin_next;
    logic [CNT_W-1:0]     eff_count;
    logic [CNT_W-1:0]     rd_pos;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_en;

    always_comb
    begin
        if (32'(count_reg) > CAP)
        begin
            eff_count = CNT_W'(CAP);
        end
        else
        begin
            eff_count = count_reg;
        end
    end

    assign status.req           = req_reg;
    assign status.active        = active_reg;
    assign status.can_start     = (eff_count != '0);
    assign status.rem_le1       = (rem_reg <= REM_W'(1));
    assign status.at_end        = (pos_reg >= eff_count);
    assign status.next_in_range = (({1'b0, pos_reg} + (CNT_W + 1)'(1)) < {1'b0, eff_count});

    assign rd_en   = cmd.rd_first | cmd.rd_cur | cmd.rd_next;
    assign rd_pos  = cmd.rd_next ? pos_reg + CNT_W'(1) : (cmd.rd_cur ? pos_reg : '0);
    assign rd_addr = ADDR_W'(rd_pos);
    assign rounded = prod_reg + ROUND_HALF;

    // event store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write && (32'(idx_reg) < MAX_EVENTS))
        begin
            store_mem[ADDR_W'(idx_reg)] <= wr_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req_t'(req_type);
            idx_reg      <= write_index;
            wr_reg.delta <= wait_ticks;
            wr_reg.kind  <= event_kind;
            wr_reg.note  <= note_in;
            wr_reg.vel   <= velocity_in;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(rdata_reg.delta) * PROD_W'(mpt_reg);
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        rem_next    = rem_reg;
        active_next = active_reg;
        nv_next     = nv_reg;
        on_next     = on_reg;
        note_next   = note_reg;
        vel_next    = vel_reg;
        fin_next    = fin_reg;
        if (cmd.capture)
        begin
            nv_next   = 1'b0;
            on_next   = 1'b0;
            note_next = '0;
            vel_next  = '0;
            fin_next  = 1'b0;
        end
        if (cmd.stop)
        begin
            active_next = 1'b0;
        end
        if (cmd.start_play)
        begin
            pos_next    = '0;
            active_next = 1'b1;
        end
        if (cmd.count_down && (rem_reg != '0))
        begin
            rem_next = rem_reg - REM_W'(1);
        end
        if (cmd.finish)
        begin
            active_next = 1'b0;
            fin_next    = 1'b1;
        end
        if (cmd.fire)
        begin
            pos_next = pos_reg + CNT_W'(1);
            if ((rdata_reg.kind == KIND_NOTE_ON) && (rdata_reg.vel != '0))
            begin
                nv_next   = 1'b1;
                on_next   = 1'b1;
                note_next = rdata_reg.note;
                vel_next  = rdata_reg.vel;
            end
            else if ((rdata_reg.kind == KIND_NOTE_ON) || (rdata_reg.kind == KIND_NOTE_OFF))
            begin
                nv_next   = 1'b1;
                note_next = rdata_reg.note;
            end
        end
        if (cmd.load)
        begin
            rem_next = rounded[PROD_W-1:FRAC_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= EVENT_COUNT_RESET;
            mpt_reg    <= MS_PER_TICK_RESET;
            pos_reg    <= '0;
            rem_reg    <= '0;
            active_reg <= 1'b0;
            nv_reg     <= 1'b0;
            on_reg     <= 1'b0;
            note_reg   <= '0;
            vel_reg    <= '0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_EVENT_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                    REG_MS_PER_TICK: mpt_reg   <= cfg_data[MPT_W-1:0];
                    default: ;
                endcase
            end
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            active_reg <= active_next;
            nv_reg     <= nv_next;
            on_reg     <= on_next;
            note_reg   <= note_next;
            vel_reg    <= vel_next;
            fin_reg    <= fin_next;
        end
    end

    assign note_valid   = nv_reg;
    assign note_on      = on_reg;
    assign note_out     = note_reg;
    assign velocity_out = vel_reg;
    assign playing      = active_reg;
    assign finished     = fin_reg;

endmodule
`default_nettype wire

>>> hw/rtl/tnes_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnes_ctrl
// Controller: steps each request through decode and, as needed, event fire,
// delay multiply and load, then presents the result for one cycle.
// ----------------------------------------------------------------------------
module tnes_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire tnes_pkg::dp_status_t status,
    output tnes_pkg::dp_cmd_t         cmd,
    output logic                      busy,
    output logic                      done
);
    import tnes_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_FIRE   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_LOAD   = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_RESP;
                unique case (status.req)
                    REQ_WRITE: cmd.mem_write = 1'b1;
                    REQ_STOP:  cmd.stop      = 1'b1;
                    REQ_START:
                    begin
                        if (!status.active && status.can_start)
                        begin
                            cmd.start_play = 1'b1;
                            cmd.rd_first   = 1'b1;
                            state_next     = ST_MUL;
                        end
                    end
                    REQ_TICK:
                    begin
                        if (status.active)
                        begin
                            cmd.count_down = 1'b1;
                            if (status.rem_le1)
                            begin
                                if (status.at_end)
                                begin
                                    cmd.finish = 1'b1;
                                end
                                else
                                begin
                                    cmd.rd_cur = 1'b1;
                                    state_next = ST_FIRE;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_FIRE:
            begin
                cmd.fire = 1'b1;
                if (status.next_in_range)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = ST_MUL;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESP);

endmodule
`default_nettype wire
